// ===== hdl/sorted_table_binary_search_defines.svh =====
// Assertion helpers shared by the search block.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define STBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/stbs_pkg.sv =====
package stbs_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 10;
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Input item operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register word indexes
  localparam logic REG_USED_SIZE = 1'b0;

  typedef struct packed {
    logic start;     // capture key and initial bounds
    logic write;     // store one table entry
    logic step;      // narrow bounds after a miss probe
    logic finish;    // capture search result
    logic hit;       // result value captured by finish
    logic load_out;  // move result to output register
  } stbs_cmd_t;

  typedef struct packed {
    logic size_zero; // no entries in use
    logic hit;       // current probe equals the key
    logic more;      // bounds still open after a miss probe
  } stbs_sts_t;

endpackage

// ===== hdl/stbs_dp.sv =====
module stbs_dp #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stbs_pkg::stbs_cmd_t           cmd,
  output stbs_pkg::stbs_sts_t           sts,
  input  logic [stbs_pkg::SIZE_W-1:0]   used_size,
  input  logic [stbs_pkg::IDX_W-1:0]    entry_index,
  input  logic signed [stbs_pkg::DATA_W-1:0] entry_value,
  input  logic signed [stbs_pkg::DATA_W-1:0] search_key,
  output logic                          found,
  output logic [stbs_pkg::POS_W-1:0]    position
);
  import stbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] key;
  logic [SW-1:0]            low, hix, mid;
  logic [SW-1:0]            low_next, hix_next, mid_next, mid_start, size_c;
  logic [SW:0]              sum_next, sum_start;
  logic [AW-1:0]            rd_addr;
  logic                     wr_ok, lt;
  logic                     res_found;
  logic [POS_W-1:0]         res_pos;

  // Clamp size to the table depth
  always_comb begin
    if (32'(used_size) > 32'(DEPTH)) begin
      size_c = SW'(DEPTH);
    end else begin
      size_c = SW'(used_size);
    end
  end

  assign sum_start = {1'b0, size_c} - (SW+1)'(1);
  assign mid_start = sum_start[SW:1];

  // Bounds: low inclusive, hix exclusive
  assign lt       = rd_data < key;
  assign low_next = lt ? (mid + SW'(1)) : low;
  assign hix_next = lt ? hix : mid;
  assign sum_next = {1'b0, low_next} + {1'b0, hix_next} - (SW+1)'(1);
  assign mid_next = sum_next[SW:1];
  assign rd_addr  = cmd.start ? AW'(mid_start) : AW'(mid_next);
  assign wr_ok    = 32'(entry_index) < 32'(DEPTH);

  assign sts.size_zero = (size_c == '0);
  assign sts.hit       = (rd_data == key);
  assign sts.more      = (low_next < hix_next);

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[AW'(entry_index)] <= entry_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= search_key;
      low <= '0;
      hix <= size_c;
      mid <= mid_start;
    end else if (cmd.step) begin
      low <= low_next;
      hix <= hix_next;
      mid <= mid_next;
    end
    if (cmd.finish) begin
      res_found <= cmd.hit;
      res_pos   <= cmd.hit ? POS_W'(mid) : '0;
    end
    if (cmd.load_out) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

  `include "sorted_table_binary_search_defines.svh"

  `STBS_ASSERT_IMP(a_step_open, cmd.step, low < hix, "probe issued with empty bounds")

endmodule

// ===== hdl/stbs_ctrl.sv =====
module stbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  output logic                out_valid,
  input  logic                out_ready,
  input  stbs_pkg::stbs_sts_t sts,
  output stbs_pkg::stbs_cmd_t cmd
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_POST  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free, take;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (take && op == OP_WRITE) begin
          cmd.write = 1'b1;
        end else if (take) begin
          cmd.start = 1'b1;
          if (sts.size_zero) begin
            cmd.finish = 1'b1;
            state_next = S_POST;
          end else begin
            state_next = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (sts.hit) begin
          cmd.finish = 1'b1;
          cmd.hit    = 1'b1;
          state_next = S_POST;
        end else if (sts.more) begin
          cmd.step   = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `include "sorted_table_binary_search_defines.svh"

  `STBS_ASSERT_NXT(a_search_probes, take && op == OP_SEARCH && !sts.size_zero, state == S_PROBE, "search did not start probing")
  `STBS_ASSERT_NXT(a_post_loads, state == S_POST && out_free, out_valid && state == S_IDLE, "result not delivered")
  `STBS_ASSERT_IMP(a_rise_from_post, $rose(out_valid), $past(state == S_POST), "result appeared outside post state")

endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// Binary search over a loaded table of signed 32-bit words. Input items with op = 0
// write entry_value at entry_index (indexes at or beyond DEPTH are dropped) and give no
// result. Input items with op = 1 search the first used_size entries (clamped to DEPTH)
// for search_key and return one result: found and the matched position, or found = 0
// with position 0. A search is accepted, probes the table unless no entries are in use,
// each probe being one read of the table memory's single read port, and then moves the
// result to the output register. One item is in flight at a time; a finished result
// waits in the output register while the next item is taken. The table is not cleared
// by reset; a search must only probe entries that were written. used_size is an APB
// register at byte address 0; the user must write it only while the block is idle,
// which the block itself does not enforce.
module sorted_table_binary_search #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [stbs_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [stbs_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [stbs_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic [stbs_pkg::IDX_W-1:0]            entry_index,
  input  logic signed [stbs_pkg::DATA_W-1:0]    entry_value,
  input  logic signed [stbs_pkg::DATA_W-1:0]    search_key,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  found,
  output logic [stbs_pkg::POS_W-1:0]            position
);
  import stbs_pkg::*;

  logic [SIZE_W-1:0] used_size;
  logic              reg_sel;
  stbs_cmd_t         cmd;
  stbs_sts_t         sts;

  // Word index: bit 2 of the byte address, byte lanes ignored
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  // Update used_size on the access phase of a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      used_size <= '0;
    end else if (psel && penable && pwrite && reg_sel == REG_USED_SIZE) begin
      used_size <= pwdata[SIZE_W-1:0];
    end
  end

  // Read back used_size; unmapped words read zero
  always_comb begin
    unique case (reg_sel)
      REG_USED_SIZE: prdata = APB_DATA_W'(used_size);
      default:       prdata = '0;
    endcase
  end

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stbs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .used_size   (used_size),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .found       (found),
    .position    (position)
  );

endmodule
